/* rtl/assert_macros.svh */
// Clocked assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(name, clk, rst_n, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(name, clk, rst_n, prop)
`define ASSERT_NEVER(name, clk, rst_n, expr)
`endif

`endif

/* rtl/lvea_pkg.sv */
package lvea_pkg;

    localparam int DOCS_DEF   = 256;
    localparam int TOPICS_DEF = 16;
    localparam int WORDS_DEF  = 1024;

    localparam int WT_W  = 16;
    localparam int VAL_W = 48;
    localparam int CNT_W = 16;
    localparam int PRD_W = 32;
    localparam int QUO_W = 32;
    localparam int NUM_W = 64;

    typedef enum logic [2:0] {
        ACT_CLEAR     = 3'd0,
        ACT_WR_THETA  = 3'd1,
        ACT_WR_PHI    = 3'd2,
        ACT_WR_TPRIOR = 3'd3,
        ACT_WR_WPRIOR = 3'd4,
        ACT_TOKEN     = 3'd5,
        ACT_RD_DT     = 3'd6,
        ACT_RD_TW     = 3'd7
    } t_action;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_CLR,
        S_CLR_LAST,
        S_RD_WAIT,
        S_P1_RD,
        S_P1_MUL,
        S_P1_ADD,
        S_P1_CHK,
        S_P2_RD,
        S_P2_MUL,
        S_P2_NUM,
        S_DIV_GO,
        S_DIV_WAIT,
        S_UPD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic th_we;
        logic ph_we;
        logic tp_we;
        logic wp_we;
        logic dt_we;
        logic tw_we;
        logic rd_en;
    } t_mem_ctl;

endpackage

/* rtl/lvea_div.sv */
module lvea_div import lvea_pkg::*; #(
    parameter int SW = 32 + $clog2(TOPICS_DEF)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [SW-1:0]    i_den,
    output logic             o_busy,
    output logic [QUO_W-1:0] o_quo
);

    // restoring divider, one quotient bit per cycle; quotient known to fit QUO_W
    logic [SW-1:0]    r_rem, n_rem;
    logic [SW-1:0]    r_den;
    logic [QUO_W-1:0] r_q, n_q;
    logic [5:0]       r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic [SW:0]      trial;
    logic             ge;

    always_comb begin
        trial  = {r_rem, r_q[QUO_W-1]};
        ge     = trial >= {1'b0, r_den};
        n_rem  = r_rem;
        n_q    = r_q;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        if (i_start) begin
            n_rem  = SW'(i_num[NUM_W-1:QUO_W]);
            n_q    = i_num[QUO_W-1:0];
            n_cnt  = 6'(QUO_W - 1);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem = ge ? trial[SW-1:0] - r_den : trial[SW-1:0];
            n_q   = {r_q[QUO_W-2:0], ge};
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd0) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_q   <= n_q;
        r_cnt <= n_cnt;
        if (i_start) begin
            r_den <= i_den;
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_q;

endmodule

/* rtl/lvea_store.sv */
module lvea_store import lvea_pkg::*; #(
    parameter int TB = $clog2(TOPICS_DEF),
    parameter int WB = $clog2(WORDS_DEF),
    parameter int DTA = $clog2(DOCS_DEF) + $clog2(TOPICS_DEF),
    parameter int TWA = $clog2(TOPICS_DEF) + $clog2(WORDS_DEF)
) (
    input  logic             i_clk,
    input  t_mem_ctl         i_ctl,
    input  logic [DTA-1:0]   i_dt_addr,
    input  logic [TWA-1:0]   i_tw_addr,
    input  logic [TB-1:0]    i_tp_addr,
    input  logic [WB-1:0]    i_wp_addr,
    input  logic [WT_W-1:0]  i_wt_data,
    input  logic [VAL_W-1:0] i_prior_data,
    input  logic [VAL_W-1:0] i_dt_data,
    input  logic [VAL_W-1:0] i_tw_data,
    output logic [WT_W-1:0]  o_th,
    output logic [WT_W-1:0]  o_ph,
    output logic [VAL_W-1:0] o_tp,
    output logic [VAL_W-1:0] o_wp,
    output logic [VAL_W-1:0] o_dt_acc,
    output logic [VAL_W-1:0] o_tw_acc
);

    logic [WT_W-1:0]  r_th_mem [2**DTA];
    logic [WT_W-1:0]  r_ph_mem [2**TWA];
    logic [VAL_W-1:0] r_tp_mem [2**TB];
    logic [VAL_W-1:0] r_wp_mem [2**WB];
    logic [VAL_W-1:0] r_dt_mem [2**DTA];
    logic [VAL_W-1:0] r_tw_mem [2**TWA];

    always_ff @(posedge i_clk) begin
        if (i_ctl.th_we) begin
            r_th_mem[i_dt_addr] <= i_wt_data;
        end
        if (i_ctl.rd_en) begin
            o_th <= r_th_mem[i_dt_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ph_we) begin
            r_ph_mem[i_tw_addr] <= i_wt_data;
        end
        if (i_ctl.rd_en) begin
            o_ph <= r_ph_mem[i_tw_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.tp_we) begin
            r_tp_mem[i_tp_addr] <= i_prior_data;
        end
        if (i_ctl.rd_en) begin
            o_tp <= r_tp_mem[i_tp_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wp_we) begin
            r_wp_mem[i_wp_addr] <= i_prior_data;
        end
        if (i_ctl.rd_en) begin
            o_wp <= r_wp_mem[i_wp_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.dt_we) begin
            r_dt_mem[i_dt_addr] <= i_dt_data;
        end
        if (i_ctl.rd_en) begin
            o_dt_acc <= r_dt_mem[i_dt_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.tw_we) begin
            r_tw_mem[i_tw_addr] <= i_tw_data;
        end
        if (i_ctl.rd_en) begin
            o_tw_acc <= r_tw_mem[i_tw_addr];
        end
    end

endmodule

/* rtl/lda_vb_expectation_accumulate.sv */
// Table writes and out-of-range items go from S_EXEC straight to S_DONE; reads pass S_RD_WAIT.
// Token: a weight pass over all topics, then per topic a bit-serial divide on the
// shared divider and an accumulator update; a zero weight sum skips the divides.
// Clear: 2**max(doc+topic, topic+word address bits) entries, one entry a cycle.
// One item at a time; the next is taken once the current result is registered.
// Synchronous active-low reset clears control only; tables and accumulators
// are undefined until written or cleared.
`include "assert_macros.svh"

module lda_vb_expectation_accumulate import lvea_pkg::*; #(
    parameter int DOCS   = DOCS_DEF,
    parameter int TOPICS = TOPICS_DEF,
    parameter int WORDS  = WORDS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [2:0]        i_action,
    input  logic [7:0]        i_doc,
    input  logic [3:0]        i_topic,
    input  logic [9:0]        i_word,
    input  logic [CNT_W-1:0]  i_count,
    input  logic [VAL_W-1:0]  i_value,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [VAL_W-1:0]  o_read_value,
    output logic              o_zero_sum,
    output logic              o_saturated
);

    localparam int DB  = (DOCS > 1) ? $clog2(DOCS) : 1;
    localparam int TB  = $clog2(TOPICS);
    localparam int WB  = $clog2(WORDS);
    localparam int DTA = DB + TB;
    localparam int TWA = TB + WB;
    localparam int CB  = (DTA > TWA) ? DTA : TWA;
    localparam int SW  = PRD_W + TB;

    t_state           r_state, n_state;
    t_action          r_act, n_act;
    logic [7:0]       r_d, n_d;
    logic [3:0]       r_t, n_t;
    logic [9:0]       r_w, n_w;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [VAL_W-1:0] r_val, n_val;
    logic [TB-1:0]    r_k, n_k;
    logic [PRD_W-1:0] r_prod, n_prod;
    logic [SW-1:0]    r_sum, n_sum;
    logic [VAL_W-1:0] r_num, n_num;
    logic [CB-1:0]    r_c, n_c;
    logic [CB-1:0]    r_cprev, n_cprev;
    logic             r_pend, n_pend;
    logic [VAL_W-1:0] r_rv, n_rv;
    logic             r_zs, n_zs;
    logic             r_sat, n_sat;
    logic             r_ov, n_ov;
    logic [VAL_W-1:0] r_orv, n_orv;
    logic             r_ozs, n_ozs;
    logic             r_osat, n_osat;

    t_mem_ctl         mem_ctl;
    logic             clr;
    logic [DTA-1:0]   dt_addr;
    logic [TWA-1:0]   tw_addr;
    logic [TB-1:0]    tp_addr;
    logic [WB-1:0]    wp_addr;
    logic [VAL_W-1:0] dt_wdata, tw_wdata;
    logic [WT_W-1:0]  th, ph;
    logic [VAL_W-1:0] tp, wp, dt_acc, tw_acc;
    logic [VAL_W:0]   dt_sum, tw_sum;
    logic             div_start, div_busy;
    logic [QUO_W-1:0] quo;
    logic             dok, tok, wok, k_last;

    assign dok    = 17'(r_d) < 17'(DOCS);
    assign tok    = 9'(r_t) < 9'(TOPICS);
    assign wok    = 17'(r_w) < 17'(WORDS);
    assign k_last = r_k == TB'(TOPICS - 1);

    assign clr     = (r_state == S_CLR) || (r_state == S_CLR_LAST);
    assign dt_addr = clr ? r_cprev[DTA-1:0] : {DB'(r_d), r_k};
    assign tw_addr = clr ? r_cprev[TWA-1:0] : {r_k, WB'(r_w)};
    assign tp_addr = clr ? r_c[TB-1:0] : r_k;
    assign wp_addr = clr ? r_c[WB-1:0] : WB'(r_w);

    assign dt_sum   = {1'b0, dt_acc} + (VAL_W + 1)'(quo);
    assign tw_sum   = {1'b0, tw_acc} + (VAL_W + 1)'(quo);
    assign dt_wdata = clr ? tp : (dt_sum[VAL_W] ? '1 : dt_sum[VAL_W-1:0]);
    assign tw_wdata = clr ? wp : (tw_sum[VAL_W] ? '1 : tw_sum[VAL_W-1:0]);

    always_comb begin
        n_state   = r_state;
        n_act     = r_act;
        n_d       = r_d;
        n_t       = r_t;
        n_w       = r_w;
        n_cnt     = r_cnt;
        n_val     = r_val;
        n_k       = r_k;
        n_prod    = r_prod;
        n_sum     = r_sum;
        n_num     = r_num;
        n_c       = r_c;
        n_cprev   = r_cprev;
        n_pend    = r_pend;
        n_rv      = r_rv;
        n_zs      = r_zs;
        n_sat     = r_sat;
        n_ov      = r_ov && i_stall;
        n_orv     = r_orv;
        n_ozs     = r_ozs;
        n_osat    = r_osat;
        mem_ctl   = '0;
        div_start = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_act   = t_action'(i_action);
                    n_d     = i_doc;
                    n_t     = i_topic;
                    n_w     = i_word;
                    n_cnt   = i_count;
                    n_val   = i_value;
                    n_k     = TB'(i_topic);
                    n_rv    = '0;
                    n_zs    = 1'b0;
                    n_sat   = 1'b0;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                unique case (r_act)
                    ACT_CLEAR: begin
                        n_c     = '0;
                        n_pend  = 1'b0;
                        n_state = S_CLR;
                    end
                    ACT_WR_THETA:  mem_ctl.th_we = dok && tok;
                    ACT_WR_PHI:    mem_ctl.ph_we = tok && wok;
                    ACT_WR_TPRIOR: mem_ctl.tp_we = tok;
                    ACT_WR_WPRIOR: mem_ctl.wp_we = wok;
                    ACT_TOKEN: begin
                        if (dok && wok) begin
                            n_k     = '0;
                            n_sum   = '0;
                            n_state = S_P1_RD;
                        end
                    end
                    ACT_RD_DT: begin
                        if (dok && tok) begin
                            mem_ctl.rd_en = 1'b1;
                            n_state       = S_RD_WAIT;
                        end
                    end
                    ACT_RD_TW: begin
                        if (tok && wok) begin
                            mem_ctl.rd_en = 1'b1;
                            n_state       = S_RD_WAIT;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_CLR: begin
                mem_ctl.rd_en = 1'b1;
                mem_ctl.dt_we = r_pend;
                mem_ctl.tw_we = r_pend;
                n_pend        = 1'b1;
                n_cprev       = r_c;
                n_c           = r_c + CB'(1);
                if (r_c == '1) begin
                    n_state = S_CLR_LAST;
                end
            end
            S_CLR_LAST: begin
                mem_ctl.dt_we = 1'b1;
                mem_ctl.tw_we = 1'b1;
                n_state       = S_DONE;
            end
            S_RD_WAIT: begin
                n_rv    = (r_act == ACT_RD_DT) ? dt_acc : tw_acc;
                n_state = S_DONE;
            end
            S_P1_RD: begin
                mem_ctl.rd_en = 1'b1;
                n_state       = S_P1_MUL;
            end
            S_P1_MUL: begin
                n_prod  = {16'd0, th} * {16'd0, ph};
                n_state = S_P1_ADD;
            end
            S_P1_ADD: begin
                n_sum = r_sum + SW'(r_prod);
                if (k_last) begin
                    n_state = S_P1_CHK;
                end else begin
                    n_k     = r_k + TB'(1);
                    n_state = S_P1_RD;
                end
            end
            S_P1_CHK: begin
                if (r_sum == '0) begin
                    n_zs    = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_k     = '0;
                    n_state = S_P2_RD;
                end
            end
            S_P2_RD: begin
                mem_ctl.rd_en = 1'b1;
                n_state       = S_P2_MUL;
            end
            S_P2_MUL: begin
                n_prod  = {16'd0, th} * {16'd0, ph};
                n_state = S_P2_NUM;
            end
            S_P2_NUM: begin
                n_num   = VAL_W'(r_cnt) * VAL_W'(r_prod);
                n_state = S_DIV_GO;
            end
            S_DIV_GO: begin
                div_start = 1'b1;
                n_state   = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (!div_busy) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                mem_ctl.dt_we = 1'b1;
                mem_ctl.tw_we = 1'b1;
                n_sat         = r_sat || dt_sum[VAL_W] || tw_sum[VAL_W];
                if (k_last) begin
                    n_state = S_DONE;
                end else begin
                    n_k     = r_k + TB'(1);
                    n_state = S_P2_RD;
                end
            end
            S_DONE: begin
                if (!r_ov || !i_stall) begin
                    n_ov    = 1'b1;
                    n_orv   = r_rv;
                    n_ozs   = r_zs;
                    n_osat  = r_sat;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act   <= n_act;
        r_d     <= n_d;
        r_t     <= n_t;
        r_w     <= n_w;
        r_cnt   <= n_cnt;
        r_val   <= n_val;
        r_k     <= n_k;
        r_prod  <= n_prod;
        r_sum   <= n_sum;
        r_num   <= n_num;
        r_c     <= n_c;
        r_cprev <= n_cprev;
        r_pend  <= n_pend;
        r_rv    <= n_rv;
        r_zs    <= n_zs;
        r_sat   <= n_sat;
        r_orv   <= n_orv;
        r_ozs   <= n_ozs;
        r_osat  <= n_osat;
    end

    lvea_store #(
        .TB  (TB),
        .WB  (WB),
        .DTA (DTA),
        .TWA (TWA)
    ) u_store (
        .i_clk        (i_clk),
        .i_ctl        (mem_ctl),
        .i_dt_addr    (dt_addr),
        .i_tw_addr    (tw_addr),
        .i_tp_addr    (tp_addr),
        .i_wp_addr    (wp_addr),
        .i_wt_data    (r_val[WT_W-1:0]),
        .i_prior_data (r_val),
        .i_dt_data    (dt_wdata),
        .i_tw_data    (tw_wdata),
        .o_th         (th),
        .o_ph         (ph),
        .o_tp         (tp),
        .o_wp         (wp),
        .o_dt_acc     (dt_acc),
        .o_tw_acc     (tw_acc)
    );

    lvea_div #(
        .SW (SW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   ({r_num, 16'd0}),
        .i_den   (r_sum),
        .o_busy  (div_busy),
        .o_quo   (quo)
    );

    assign o_stall      = r_state != S_IDLE;
    assign o_valid      = r_ov;
    assign o_read_value = r_orv;
    assign o_zero_sum   = r_ozs;
    assign o_saturated  = r_osat;

    `ASSERT_CLK(a_div_start_idle, i_clk, i_rst_n, div_start |-> !div_busy)
    `ASSERT_CLK(a_acc_wr_no_div, i_clk, i_rst_n, (mem_ctl.dt_we || mem_ctl.tw_we) |-> !div_busy)
    `ASSERT_NEVER(a_flags_excl, i_clk, i_rst_n, o_valid && o_zero_sum && o_saturated)
    `ASSERT_CLK(a_done_free, i_clk, i_rst_n, (r_state == S_DONE) && !o_valid |=> o_valid)

endmodule
